[src/sgcm_pkg.sv]
// Shared types, register codes and arithmetic helpers for the Sobel colour-map filter.
`timescale 1ns / 1ps

package sgcm_pkg;

    // Default line store depth (pixels per row)
    localparam int SGCM_MAX_LINE_WIDTH = 256;

    // Width used for row and column limit compares
    localparam int SGCM_CMP_W = 13;

    // Configuration register layout
    localparam int SGCM_CFG_IDX_W  = 2;
    localparam int SGCM_CFG_DATA_W = 13;
    localparam int SGCM_WIDTH_W    = 9;
    localparam int SGCM_HEIGHT_W   = 13;

    localparam logic [SGCM_CFG_IDX_W-1:0] SGCM_CFG_WIDTH  = 2'd0;
    localparam logic [SGCM_CFG_IDX_W-1:0] SGCM_CFG_HEIGHT = 2'd1;
    localparam logic [SGCM_CFG_IDX_W-1:0] SGCM_CFG_DIR    = 2'd2;

    localparam logic [SGCM_WIDTH_W-1:0]  SGCM_WIDTH_RST  = 9'd256;
    localparam logic [SGCM_HEIGHT_W-1:0] SGCM_HEIGHT_RST = 13'd256;

    localparam logic SGCM_DIR_X = 1'b0;
    localparam logic SGCM_DIR_Y = 1'b1;

    localparam int SGCM_SUM_W  = 11;
    localparam int SGCM_OUT_DW = 40;

    // One window column: top, middle and bottom pixel
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } t_column;

    // One result item
    typedef struct packed {
        logic [SGCM_SUM_W-1:0] sum;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic                  frame_end;
        logic                  last;
    } t_result;

    // Up to two results handed from the window stage to the output buffer
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_result_pair;

    function automatic logic [11:0] col_weight(input t_column col);
        col_weight = 12'(col.top) + {3'b000, col.mid, 1'b0} + 12'(col.bot);
    endfunction

    function automatic logic [11:0] row_weight(input logic [7:0] l, input logic [7:0] c,
                                               input logic [7:0] r);
        row_weight = 12'(l) + {3'b000, c, 1'b0} + 12'(r);
    endfunction

    // Sobel sum over three window columns, left to right
    function automatic logic [SGCM_SUM_W-1:0] kernel_sum(input t_column left,
                                                         input t_column centre,
                                                         input t_column right,
                                                         input logic    dir);
        logic [11:0] diff;
        if (dir == SGCM_DIR_X) begin
            diff = col_weight(right) - col_weight(left);
        end else begin
            diff = row_weight(left.bot, centre.bot, right.bot)
                 - row_weight(left.top, centre.top, right.top);
        end
        kernel_sum = diff[SGCM_SUM_W-1:0];
    endfunction

    // Build a result: scale magnitude by 1/8, shade toward red or blue by sign
    function automatic t_result make_result(input logic [SGCM_SUM_W-1:0] sum,
                                            input logic fend, input logic last);
        logic [SGCM_SUM_W-1:0] mag;
        logic [7:0]            lvl;
        t_result               res;
        mag = sum[SGCM_SUM_W-1] ? (~sum + 1'b1) : sum;
        lvl = 8'd255 - {1'b0, mag[9:3]};
        res.sum       = sum;
        res.red       = 8'd255;
        res.green     = 8'd255;
        res.blue      = 8'd255;
        res.frame_end = fend;
        res.last      = last;
        if (sum[SGCM_SUM_W-1]) begin
            res.red   = lvl;
            res.green = lvl;
        end else if (sum != '0) begin
            res.green = lvl;
            res.blue  = lvl;
        end
        make_result = res;
    endfunction

endpackage

[src/sgcm_line_store.sv]
// Two-line pixel store: upper and middle line packed in one synchronous memory.
`timescale 1ns / 1ps

module sgcm_line_store #(
    parameter int DEPTH = sgcm_pkg::SGCM_MAX_LINE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [15:0]              o_rd_data,   // [7:0] middle line, [15:8] upper line
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [15:0]              i_wr_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/sgcm_out_buf.sv]
// Two-entry output buffer that serializes up to two results per pixel onto the stream.
`timescale 1ns / 1ps

module sgcm_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sgcm_pkg::t_result_pair i_pair,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_take,
    output sgcm_pkg::t_result     o_res
);

    logic [1:0]        r_cnt, n_cnt;
    sgcm_pkg::t_result r_ent0, n_ent0;
    sgcm_pkg::t_result r_ent1, n_ent1;
    logic              take;

    assign take    = i_take && (r_cnt != 2'd0);
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && take);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_ent0;

    always_comb begin
        n_cnt  = r_cnt;
        n_ent0 = r_ent0;
        n_ent1 = r_ent1;
        if (take) begin
            n_ent0 = r_ent1;
            n_cnt  = r_cnt - 2'd1;
        end
        if (i_load) begin
            priority if (i_pair.a_valid && i_pair.b_valid) begin
                n_ent0 = i_pair.a;
                n_ent1 = i_pair.b;
                n_cnt  = 2'd2;
            end else if (i_pair.a_valid) begin
                n_ent0 = i_pair.a;
                n_cnt  = 2'd1;
            end else if (i_pair.b_valid) begin
                n_ent0 = i_pair.b;
                n_cnt  = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent0 <= n_ent0;
        r_ent1 <= n_ent1;
    end

endmodule

[src/sobel_gradient_colour_map.sv]
// Top level of the streaming 3x3 Sobel filter with colour visualisation.
//
// Usage: grey pixels enter in raster order on the s_axis channel, one per request
// (tdata = pixel_value, tuser = pad flag). After the last image row, send one full
// row of pad requests to flush the last row out. Results leave on m_axis: tdata
// packs gradient_sum, red, green, blue; tuser is frame_end; tlast marks the final
// result caused by one input request. The result for pixel (y, x) appears once
// pixel (y+1, x+1) has arrived; the last column gives two results on one request.
// Write width, height and direction on the cfg channel while no request is in
// flight; cfg_ready is always high.
// Throughput: one pixel per clock. A row of W pixels gives W results (none for
// column 0, two for the last column), so an always-ready receiver never stalls
// the input. A request's first result reaches m_axis through the line store
// read, then the output buffer.
// Reset clears the row and column position, the window and the configuration
// (width 256, height 256, x kernel); the line stores need no clearing pass.
// When the receiver stalls, results wait in the two-entry buffer, which takes a
// new pair only when empty or when its one entry is being taken; a pixel with
// results then holds in the window stage and s_axis_tready drops.
`timescale 1ns / 1ps

module sobel_gradient_colour_map #(
    parameter int MAX_LINE_WIDTH = sgcm_pkg::SGCM_MAX_LINE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [7:0]                           i_s_axis_tdata,  // [7:0] pixel_value
    input  logic                                 i_s_axis_tuser,  // [0] pad_item
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [10:0] gradient_sum, [18:11] red_level, [26:19] green_level,
    // [34:27] blue_level, [39:35] zero
    output logic [sgcm_pkg::SGCM_OUT_DW-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tuser,  // [0] frame_end
    output logic                                 o_m_axis_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sgcm_pkg::SGCM_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sgcm_pkg::SGCM_CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_LINE_WIDTH);
    localparam int CW = sgcm_pkg::SGCM_CMP_W;

    // configuration
    logic [sgcm_pkg::SGCM_WIDTH_W-1:0]  r_cfg_width;
    logic [sgcm_pkg::SGCM_HEIGHT_W-1:0] r_cfg_height;
    logic                               r_cfg_dir;

    // position
    logic [AW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;

    // accept-side decode
    logic          s_accept;
    logic [CW-1:0] w_eff, h_eff;
    logic [AW-1:0] s0_c;
    logic          s0_flush, s0_last_col;

    // window stage
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_c;
    logic [7:0]    r_s1_pixel;
    logic          r_s1_row_ge1, r_s1_row_ge2, r_s1_flush, r_s1_last_col;
    logic          r_s1_c_ge1, r_s1_c_eq1;
    logic          s1_adv, s1_has_res;

    sgcm_pkg::t_column r_win0, r_win1;
    sgcm_pkg::t_column s1_col, s1_left;

    logic [15:0] mem_rd_data;
    logic [7:0]  s1_mid, s1_up;

    logic [sgcm_pkg::SGCM_SUM_W-1:0] sum_a, sum_b;
    sgcm_pkg::t_result_pair          pair;
    logic                            buf_ready;
    sgcm_pkg::t_result               out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sgcm_pkg::SGCM_WIDTH_RST;
            r_cfg_height <= sgcm_pkg::SGCM_HEIGHT_RST;
            r_cfg_dir    <= sgcm_pkg::SGCM_DIR_X;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sgcm_pkg::SGCM_CFG_WIDTH:  r_cfg_width  <= i_cfg_data[sgcm_pkg::SGCM_WIDTH_W-1:0];
                sgcm_pkg::SGCM_CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                sgcm_pkg::SGCM_CFG_DIR:    r_cfg_dir    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp width to [2, MAX_LINE_WIDTH], height to at least 2
    always_comb begin
        w_eff = CW'(r_cfg_width);
        if (w_eff < CW'(2)) begin
            w_eff = CW'(2);
        end else if (w_eff > CW'(MAX_LINE_WIDTH)) begin
            w_eff = CW'(MAX_LINE_WIDTH);
        end
        h_eff = (r_cfg_height < CW'(2)) ? CW'(2) : r_cfg_height;
    end

    assign s0_c        = (CW'(r_col) >= w_eff) ? AW'(w_eff - CW'(1)) : r_col;
    assign s0_last_col = (s0_c == AW'(w_eff - CW'(1)));
    assign s0_flush    = (r_row >= h_eff);

    assign s1_has_res      = r_s1_row_ge1 && (r_s1_c_ge1 || r_s1_last_col);
    assign s1_adv          = r_s1_valid && (!s1_has_res || buf_ready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s_accept) begin
            if (s0_last_col) begin
                n_col = '0;
                n_row = s0_flush ? '0 : r_row + CW'(1);
            end else begin
                n_col = s0_c + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_c        <= s0_c;
            r_s1_pixel    <= i_s_axis_tdata;
            r_s1_row_ge1  <= (r_row >= CW'(1));
            r_s1_row_ge2  <= (r_row >= CW'(2));
            r_s1_flush    <= s0_flush;
            r_s1_last_col <= s0_last_col;
            r_s1_c_ge1    <= (s0_c != '0);
            r_s1_c_eq1    <= (s0_c == AW'(1));
        end
    end

    // line store: read on accept, write back when a non-flush pixel advances;
    // consecutive pixels never share a column, so no forwarding is needed
    sgcm_line_store #(
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (s0_c),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (s1_adv && !r_s1_flush),
        .i_wr_addr (r_s1_c),
        .i_wr_data ({s1_mid, r_s1_pixel})
    );

    assign s1_mid = mem_rd_data[7:0];
    assign s1_up  = mem_rd_data[15:8];

    // clamp at the top edge and at the flush row
    assign s1_col.top = r_s1_row_ge2 ? s1_up : s1_mid;
    assign s1_col.mid = s1_mid;
    assign s1_col.bot = r_s1_flush ? s1_mid : r_s1_pixel;
    assign s1_left    = r_s1_c_eq1 ? r_win0 : r_win1;

    assign sum_a = sgcm_pkg::kernel_sum(s1_left, r_win0, s1_col, r_cfg_dir);
    assign sum_b = sgcm_pkg::kernel_sum(r_win0, s1_col, s1_col, r_cfg_dir);

    assign pair.a_valid = r_s1_row_ge1 && r_s1_c_ge1;
    assign pair.b_valid = r_s1_row_ge1 && r_s1_last_col;
    assign pair.a       = sgcm_pkg::make_result(sum_a, 1'b0, !r_s1_last_col);
    assign pair.b       = sgcm_pkg::make_result(sum_b, r_s1_flush, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (s1_adv) begin
            r_win1 <= r_win0;
            r_win0 <= s1_col;
        end
    end

    sgcm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv && s1_has_res),
        .i_pair  (pair),
        .o_ready (buf_ready),
        .o_valid (o_m_axis_tvalid),
        .i_take  (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {5'b00000, out_res.blue, out_res.green, out_res.red, out_res.sum};
    assign o_m_axis_tuser = out_res.frame_end;
    assign o_m_axis_tlast = out_res.last;

    // a line store read never hits the column being written in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_accept && s1_adv && !r_s1_flush && (s0_c == r_s1_c)))
        else $error("line store read and write collide on one column");

    // frame end always closes the results of its request
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("frame end result without tlast");

    // a stalled window stage blocks new requests
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !o_s_axis_tready)
        else $error("input accepted while window stage is stalled");

    // the last column of a row wraps the column position
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s0_last_col) |=> (r_col == '0))
        else $error("column position did not wrap after last column");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Sobel colour-map filter: directed and random frames.
`timescale 1ns / 1ps

module tb_top;
    import sgcm_pkg::*;

    // Shadow of the filter: line stores, window and position, plus the colours still due
    class sobel_shadow;
        logic [7:0]               upper_row  [SGCM_MAX_LINE_WIDTH];
        logic [7:0]               middle_row [SGCM_MAX_LINE_WIDTH];
        t_column                  near_col;
        t_column                  far_col;
        int unsigned              col_pos;
        int unsigned              row_pos;
        logic [SGCM_WIDTH_W-1:0]  width_reg;
        logic [SGCM_HEIGHT_W-1:0] height_reg;
        logic                     dir_reg;
        t_result                  colour_queue [$];
        int unsigned              mismatches;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            near_col   = '0;
            far_col    = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = SGCM_WIDTH_RST;
            height_reg = SGCM_HEIGHT_RST;
            dir_reg    = SGCM_DIR_X;
            mismatches = 0;
        endfunction

        function void set_reg(logic [SGCM_CFG_IDX_W-1:0] idx,
                              logic [SGCM_CFG_DATA_W-1:0] data);
            case (idx)
                SGCM_CFG_WIDTH:  width_reg  = data[SGCM_WIDTH_W-1:0];
                SGCM_CFG_HEIGHT: height_reg = data[SGCM_HEIGHT_W-1:0];
                SGCM_CFG_DIR:    dir_reg    = data[0];
                default: ;
            endcase
        endfunction

        function int gradient(t_column l, t_column m, t_column r);
            if (dir_reg == SGCM_DIR_X) begin
                return (int'(r.top) + 2 * int'(r.mid) + int'(r.bot))
                     - (int'(l.top) + 2 * int'(l.mid) + int'(l.bot));
            end
            return (int'(l.bot) + 2 * int'(m.bot) + int'(r.bot))
                 - (int'(l.top) + 2 * int'(m.top) + int'(r.top));
        endfunction

        function void add_colour(int s, logic fend, logic last);
            t_result     res;
            int unsigned lvl;
            lvl           = 255 - ((s < 0 ? -s : s) >> 3);
            res.sum       = SGCM_SUM_W'(s);
            res.red       = 8'd255;
            res.green     = 8'd255;
            res.blue      = 8'd255;
            res.frame_end = fend;
            res.last      = last;
            if (s > 0) begin
                res.green = 8'(lvl);
                res.blue  = 8'(lvl);
            end else if (s < 0) begin
                res.red   = 8'(lvl);
                res.green = 8'(lvl);
            end
            colour_queue.push_back(res);
        endfunction

        // The row position alone decides between pixel and flush; the pad flag is not used
        function void take_pixel(logic [7:0] level);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            logic        flush;
            logic        last_col;
            t_column     cur;
            w = width_reg;
            if (w < 2) w = 2;
            if (w > SGCM_MAX_LINE_WIDTH) w = SGCM_MAX_LINE_WIDTH;
            h        = height_reg < 2 ? 2 : height_reg;
            c        = col_pos >= w ? w - 1 : col_pos;
            r        = row_pos;
            flush    = r >= h;
            last_col = c == w - 1;
            cur.mid  = middle_row[c];
            cur.top  = r >= 2 ? upper_row[c] : cur.mid;
            cur.bot  = flush ? cur.mid : level;
            if (r >= 1) begin
                if (c >= 1) begin
                    add_colour(gradient(c == 1 ? near_col : far_col, near_col, cur),
                               1'b0, !last_col);
                end
                // right border clamps onto the current column
                if (last_col) begin
                    add_colour(gradient(near_col, cur, cur), flush, 1'b1);
                end
            end
            if (!flush) begin
                upper_row[c]  = middle_row[c];
                middle_row[c] = level;
            end
            far_col  = near_col;
            near_col = cur;
            if (last_col) begin
                col_pos = 0;
                row_pos = flush ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 200) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
                end
            end
        endfunction

        function void check_result(logic [SGCM_OUT_DW-1:0] data, logic fend, logic last);
            t_result want;
            if (colour_queue.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, data);
                return;
            end
            want = colour_queue.pop_front();
            compare_field("gradient_sum", $signed(want.sum), $signed(data[10:0]));
            compare_field("red_level", want.red, data[18:11]);
            compare_field("green_level", want.green, data[26:19]);
            compare_field("blue_level", want.blue, data[34:27]);
            compare_field("frame_end", want.frame_end, fend);
            compare_field("last_in_run", want.last, last);
        endfunction

        function int pending();
            return colour_queue.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [7:0]                 i_s_axis_tdata;
    logic                       i_s_axis_tuser;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready;
    logic [SGCM_OUT_DW-1:0]     o_m_axis_tdata;
    logic                       o_m_axis_tuser;
    logic                       o_m_axis_tlast;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [SGCM_CFG_IDX_W-1:0]  i_cfg_index;
    logic [SGCM_CFG_DATA_W-1:0] i_cfg_data;

    sobel_shadow shadow;
    bit          calm;
    int          pixels_sent;

    sobel_gradient_colour_map dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Favor the extremes so that large gradients of both signs show up often
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [SGCM_CFG_IDX_W-1:0] idx,
                             input logic [SGCM_CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_reg(idx, data);
    endtask

    task automatic send_pixel(input logic [7:0] level, input logic pad);
        int gap;
        gap = draw_wait();
        // drop a configuration request still held from the last write
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= level;
        i_s_axis_tuser  <= pad;
        do @(posedge i_clk); while (!o_s_axis_tready);
        shadow.take_pixel(level);
        pixels_sent++;
    endtask

    // Hold off until every colour has come back, then let the pipeline empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_frame(input int cols, input int rows);
        for (int r = 0; r <= rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (r < rows) begin
                    send_pixel(pick_level(), $urandom_range(0, 7) == 0);
                end else begin
                    send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 5) != 0);
                end
            end
        end
    endtask

    // Result side: random stalls, check every accepted result
    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            shadow.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    initial begin
        int w_raw;
        int h_raw;
        int w_eff;
        int h_eff;
        int phase;
        shadow          = new();
        calm            = 1'b0;
        pixels_sent     = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= SGCM_CFG_WIDTH;
        i_cfg_data      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 frame, x kernel: dark left edge, bright right edge gives the top sum;
        // pad flag inside an image row, a plain pixel inside the flush row
        write_reg(SGCM_CFG_WIDTH, 3);
        write_reg(SGCM_CFG_HEIGHT, 2);
        write_reg(SGCM_CFG_DIR, SGCM_DIR_X);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b1);
        settle();

        // y kernel, bright over dark: the lowest sum on every pixel
        write_reg(SGCM_CFG_DIR, SGCM_DIR_Y);
        repeat (3) send_pixel(8'd255, 1'b0);
        repeat (3) send_pixel(8'd0, 1'b0);
        repeat (3) send_pixel(8'd0, 1'b1);
        settle();

        // width and height below range clamp to 2
        write_reg(SGCM_CFG_WIDTH, 0);
        write_reg(SGCM_CFG_HEIGHT, 1);
        write_reg(SGCM_CFG_DIR, SGCM_DIR_X);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'd0, 1'b1);
        settle();

        // shrink mid-frame: column past the new width ends the row,
        // row past the new height becomes the flush row
        write_reg(SGCM_CFG_HEIGHT, 4095);
        write_reg(SGCM_CFG_WIDTH, 256);
        write_reg(SGCM_CFG_HEIGHT, 4096);
        repeat (10) send_pixel(pick_level(), 1'b0);
        settle();
        write_reg(SGCM_CFG_WIDTH, 4);
        repeat (9) send_pixel(pick_level(), 1'b0);
        settle();
        write_reg(SGCM_CFG_HEIGHT, 2);
        repeat (4) send_pixel(8'($urandom_range(0, 255)), 1'b1);
        settle();

        phase = 0;
        while (pixels_sent < 450) begin
            calm = $urandom_range(0, 3) == 0;
            case ($urandom_range(0, 9))
                0: w_raw = $urandom_range(0, 1);
                1: w_raw = $urandom_range(9, 40);
                default: w_raw = $urandom_range(2, 8);
            endcase
            h_raw = $urandom_range(0, 6) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 5);
            write_reg(SGCM_CFG_WIDTH, SGCM_CFG_DATA_W'(w_raw));
            write_reg(SGCM_CFG_HEIGHT, SGCM_CFG_DATA_W'(h_raw));
            write_reg(SGCM_CFG_DIR, $urandom_range(0, 1) ? SGCM_DIR_Y : SGCM_DIR_X);
            w_eff = w_raw < 2 ? 2 : w_raw;
            h_eff = h_raw < 2 ? 2 : h_raw;
            run_frame(w_eff, h_eff);
            settle();
            // one full-width row; width above range saturates to the line store depth,
            // then narrow the frame for the rows that carry the results
            if (phase == 3) begin
                calm = 1'b0;
                write_reg(SGCM_CFG_WIDTH, 511);
                write_reg(SGCM_CFG_HEIGHT, 0);
                repeat (SGCM_MAX_LINE_WIDTH) send_pixel(pick_level(), 1'b0);
                settle();
                write_reg(SGCM_CFG_WIDTH, 3);
                repeat (3) send_pixel(pick_level(), 1'b0);
                repeat (3) send_pixel(pick_level(), 1'b1);
                settle();
            end
            phase++;
        end
        calm = 1'b0;
        settle();

        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
